// ===== rtl/core/rfsl_pkg.sv =====
// shared types and codes for the ready queue and sleep list scheduler core
package rfsl_pkg;

  // field widths fixed by the transaction format
  localparam int ID_W    = 8;
  localparam int TICKS_W = 16;

  // operation codes
  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_FETCH   = 3'd1,
    OP_REQUEUE = 3'd2,
    OP_SLEEP   = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_DISCARD = 2'd3
  } status_t;

  // process state codes for requeue
  localparam logic [1:0] PS_WAIT     = 2'd1;
  localparam logic [1:0] PS_FINISHED = 2'd2;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_TICK
  } state_t;

  // ready fifo control and status
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/ready_fifo_with_sleep_list.sv =====
// scheduler core top level: ready queue, sleep list memory and tick walker
// add, fetch, requeue, sleep and tick on an empty sleep list strobe out_valid in the cycle
//   after the transaction is accepted; a tick over a non-empty sleep list strobes once its walk ends
// throughput: one transaction per cycle, except a tick holds busy while it
//   walks the sleep list memory one entry per cycle (read, decrement, write back)
// reset: synchronous, both queues empty; the receiver cannot stall, each result shows once
module ready_fifo_with_sleep_list #(
  parameter int READY_DEPTH = 64,
  parameter int SLEEP_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [2:0]                         in_op,
  input  logic [7:0]                         in_proc_id,
  input  logic [1:0]                         in_proc_state,
  input  logic [15:0]                        in_sleep_ticks,
  output logic                               out_valid,
  output logic                               out_got_process,
  output logic [7:0]                         out_proc_id,
  output logic [1:0]                         out_status,
  output logic [$clog2(READY_DEPTH+1)-1:0]   out_ready_count,
  output logic [$clog2(SLEEP_DEPTH+1)-1:0]   out_wait_count
);

  localparam int RCW   = $clog2(READY_DEPTH + 1);
  localparam int SCW   = $clog2(SLEEP_DEPTH + 1);
  localparam int SAW   = $clog2(SLEEP_DEPTH);
  localparam int ENT_W = rfsl_pkg::ID_W + rfsl_pkg::TICKS_W;

  rfsl_pkg::state_t          state_r, state_nxt;
  logic [SCW-1:0]            sleep_fill_r, sleep_fill_nxt;
  logic [SCW-1:0]            idx_r, idx_nxt;
  logic [SCW-1:0]            keep_r, keep_nxt;
  logic                      tick_full_r, tick_full_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_got_r, out_got_nxt;
  rfsl_pkg::status_t         out_status_r, out_status_nxt;

  logic [ENT_W-1:0]          sleep_mem [SLEEP_DEPTH];
  logic [ENT_W-1:0]          sleep_rd_r;
  logic                      sleep_we;
  logic [SAW-1:0]            sleep_waddr;
  logic [ENT_W-1:0]          sleep_wdata;
  logic                      sleep_re;
  logic [SAW-1:0]            sleep_raddr;

  rfsl_pkg::fifo_ctl_t       fifo_ctl;
  rfsl_pkg::fifo_stat_t      fifo_stat;
  logic [rfsl_pkg::ID_W-1:0] fifo_push_id;
  logic [rfsl_pkg::ID_W-1:0] fifo_rd_id;
  logic [RCW-1:0]            ready_fill;

  logic                      acc;
  rfsl_pkg::op_t             op;
  logic                      want_ready, want_sleep, want_discard;
  logic                      sleep_full, walk_last;
  logic [rfsl_pkg::ID_W-1:0]    rd_id;
  logic [rfsl_pkg::TICKS_W-1:0] rd_left, left_dec;
  logic                      due, tick_push;

  // transaction decode
  assign acc          = start && !busy;
  assign op           = rfsl_pkg::op_t'(in_op);
  assign want_discard = (op == rfsl_pkg::OP_REQUEUE) && (in_proc_state == rfsl_pkg::PS_FINISHED);
  assign want_sleep   = (op == rfsl_pkg::OP_SLEEP) ||
                        ((op == rfsl_pkg::OP_REQUEUE) && (in_proc_state == rfsl_pkg::PS_WAIT));
  assign want_ready   = (op == rfsl_pkg::OP_ADD) ||
                        ((op == rfsl_pkg::OP_REQUEUE) && !want_discard && !want_sleep);
  assign sleep_full   = (sleep_fill_r == SCW'(SLEEP_DEPTH));
  assign walk_last    = (idx_r == sleep_fill_r);

  // sleep entry under the walker: saturating decrement, due at zero
  assign rd_id     = sleep_rd_r[ENT_W-1 -: rfsl_pkg::ID_W];
  assign rd_left   = sleep_rd_r[rfsl_pkg::TICKS_W-1:0];
  assign left_dec  = (rd_left == '0) ? '0 : rd_left - rfsl_pkg::TICKS_W'(1);
  assign due       = (left_dec == '0);
  assign tick_push = due && !fifo_stat.full;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfsl_pkg::S_IDLE: begin
        if (acc && (op == rfsl_pkg::OP_TICK) && (sleep_fill_r != '0)) begin
          state_nxt = rfsl_pkg::S_TICK;
        end
      end
      rfsl_pkg::S_TICK: begin
        if (walk_last) begin
          state_nxt = rfsl_pkg::S_IDLE;
        end
      end
      default: state_nxt = rfsl_pkg::S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    sleep_fill_nxt = sleep_fill_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    tick_full_nxt  = tick_full_r;
    out_valid_nxt  = 1'b0;
    out_got_nxt    = 1'b0;
    out_status_nxt = rfsl_pkg::ST_OK;
    fifo_ctl       = '0;
    fifo_push_id   = in_proc_id;
    sleep_we       = 1'b0;
    sleep_waddr    = sleep_fill_r[SAW-1:0];
    sleep_wdata    = {in_proc_id, in_sleep_ticks};
    sleep_re       = 1'b0;
    sleep_raddr    = '0;
    unique case (state_r)
      rfsl_pkg::S_IDLE: begin
        sleep_re = 1'b1;
        if (acc) begin
          out_valid_nxt = 1'b1;
          if (want_discard) begin
            out_status_nxt = rfsl_pkg::ST_DISCARD;
          end else if (want_ready) begin
            if (fifo_stat.full) begin
              out_status_nxt = rfsl_pkg::ST_FULL;
            end else begin
              fifo_ctl.push = 1'b1;
            end
          end else if (want_sleep) begin
            if (sleep_full) begin
              out_status_nxt = rfsl_pkg::ST_FULL;
            end else begin
              sleep_we       = 1'b1;
              sleep_fill_nxt = sleep_fill_r + SCW'(1);
            end
          end else if (op == rfsl_pkg::OP_FETCH) begin
            if (fifo_stat.empty) begin
              out_status_nxt = rfsl_pkg::ST_EMPTY;
            end else begin
              fifo_ctl.pop = 1'b1;
              out_got_nxt  = 1'b1;
            end
          end else if ((op == rfsl_pkg::OP_TICK) && (sleep_fill_r != '0)) begin
            // entry 0 is read this cycle, walk starts next cycle
            out_valid_nxt = 1'b0;
            idx_nxt       = SCW'(1);
            keep_nxt      = '0;
            tick_full_nxt = 1'b0;
          end
        end
      end
      rfsl_pkg::S_TICK: begin
        // due entry goes to the ready queue, otherwise compacts to slot keep
        fifo_push_id  = rd_id;
        fifo_ctl.push = tick_push;
        sleep_we      = !tick_push;
        sleep_waddr   = keep_r[SAW-1:0];
        sleep_wdata   = {rd_id, left_dec};
        keep_nxt      = keep_r + SCW'(!tick_push);
        tick_full_nxt = tick_full_r || (due && fifo_stat.full);
        if (walk_last) begin
          sleep_fill_nxt = keep_nxt;
          out_valid_nxt  = 1'b1;
          out_status_nxt = tick_full_nxt ? rfsl_pkg::ST_FULL : rfsl_pkg::ST_OK;
        end else begin
          sleep_re    = 1'b1;
          sleep_raddr = idx_r[SAW-1:0];
          idx_nxt     = idx_r + SCW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rfsl_pkg::S_IDLE;
      sleep_fill_r <= '0;
      idx_r        <= '0;
      keep_r       <= '0;
      tick_full_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      out_got_r    <= 1'b0;
      out_status_r <= rfsl_pkg::ST_OK;
    end else begin
      state_r      <= state_nxt;
      sleep_fill_r <= sleep_fill_nxt;
      idx_r        <= idx_nxt;
      keep_r       <= keep_nxt;
      tick_full_r  <= tick_full_nxt;
      out_valid_r  <= out_valid_nxt;
      out_got_r    <= out_got_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // sleep list memory: write at keep or fill, registered read ahead of the walker
  always_ff @(posedge clk) begin
    if (sleep_we) begin
      sleep_mem[sleep_waddr] <= sleep_wdata;
    end
    if (sleep_re) begin
      sleep_rd_r <= sleep_mem[sleep_raddr];
    end
  end

  rfsl_ready_fifo #(
    .DEPTH (READY_DEPTH)
  ) u_ready (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .push_id (fifo_push_id),
    .rd_id   (fifo_rd_id),
    .fill    (ready_fill),
    .stat    (fifo_stat)
  );

  // result ports: counts are stable through the strobe cycle
  assign busy            = (state_r != rfsl_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_got_process = out_got_r;
  assign out_proc_id     = out_got_r ? fifo_rd_id : '0;
  assign out_status      = out_status_r;
  assign out_ready_count = ready_fill;
  assign out_wait_count  = sleep_fill_r;

  // a result is only shown once the walker is back at rest
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result strobe while tick walk in progress");

  // compaction write never reaches the entry being read ahead
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfsl_pkg::S_TICK) |-> (keep_r < idx_r))
    else $error("sleep write slot overtakes read slot");

  // a fetch that returns an id reports ok
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_got_process) |-> (out_status == rfsl_pkg::ST_OK))
    else $error("fetched id with non-ok status");

  // an accepted add into a queue with room grows it by one
  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (op == rfsl_pkg::OP_ADD) && !fifo_stat.full) |=>
      (ready_fill == $past(ready_fill) + RCW'(1)))
    else $error("ready count did not advance on add");

endmodule

// ===== rtl/core/rfsl_ready_fifo.sv =====
// ready queue: circular fifo of process ids in a synchronous memory
module rfsl_ready_fifo #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rfsl_pkg::fifo_ctl_t           ctl,
  input  logic [rfsl_pkg::ID_W-1:0]     push_id,
  output logic [rfsl_pkg::ID_W-1:0]     rd_id,
  output logic [$clog2(DEPTH+1)-1:0]    fill,
  output rfsl_pkg::fifo_stat_t          stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [rfsl_pkg::ID_W-1:0] mem [DEPTH];
  logic [rfsl_pkg::ID_W-1:0] rd_id_r;
  logic [AW-1:0]             head_r, head_nxt;
  logic [AW-1:0]             tail_r, tail_nxt;
  logic [CW-1:0]             fill_r, fill_nxt;

  // pointer wrap and occupancy
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.push) begin
      tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
    end
    if (ctl.pop) begin
      head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    end
    if (ctl.push && !ctl.pop) begin
      fill_nxt = fill_r + CW'(1);
    end else if (ctl.pop && !ctl.push) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_id;
    end
    if (ctl.pop) begin
      rd_id_r <= mem[head_r];
    end
  end

  assign rd_id      = rd_id_r;
  assign fill       = fill_r;
  assign stat.full  = (fill_r == CW'(DEPTH));
  assign stat.empty = (fill_r == '0);

endmodule
